// ----- rtl/tcw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: grid geometry,
// control codes, operation codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Grid geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_WIDTH  = 8;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // Internal widths derived from the geometry
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(COLUMNS + TAB_WIDTH);
    localparam int ROW_W  = $clog2(ROWS + 1);

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int CADDR_W  = 11;
    localparam int LOC_W    = 11;
    localparam int CELL_W   = 16;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // Operations carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BACKGROUND = 2'd0,
        REG_BLANK_FG   = 2'd1
    } cfg_reg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_COPY_TAIL,
        ST_FILL,
        ST_READ,
        ST_RESP
    } state_t;

    // Sweep pointer start points
    typedef enum logic [1:0] {
        PTR_ZERO,
        PTR_SECOND_ROW,
        PTR_LAST_ROW
    } ptr_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     capture;
        logic     put;
        logic     home;
        logic     copy_step;
        logic     fill_step;
        logic     rd_cell;
        logic     latch_data;
        logic     ptr_load;
        ptr_sel_t ptr_sel;
        logic     load_out;
    } tcw_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic need_roll;
        logic ptr_last;
        logic out_free;
    } tcw_status_t;

    // Linear cell index of a grid position
    function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(COLUMNS);
        return base + ADDR_W'(col);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tcw_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: sequences accept, execute, cell sweeps (row copy, blank fill),
// cell read and result hand-off for the text console datapath.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t         cmd
);
    import tcw_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                case (status.op)
                    OP_PUT:   state_next = status.need_roll ? ST_COPY : ST_RESP;
                    OP_CLEAR: state_next = ST_FILL;
                    OP_READ:  state_next = ST_READ;
                    default:  state_next = ST_RESP;
                endcase
            end
            ST_COPY: begin
                if (status.ptr_last) state_next = ST_COPY_TAIL;
            end
            ST_COPY_TAIL: state_next = ST_FILL;
            ST_FILL: begin
                if (status.ptr_last) state_next = ST_RESP;
            end
            ST_READ: state_next = ST_RESP;
            ST_RESP: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC: begin
                case (status.op)
                    OP_PUT: begin
                        cmd.put      = 1'b1;
                        cmd.ptr_load = status.need_roll;
                        cmd.ptr_sel  = PTR_SECOND_ROW;
                    end
                    OP_CLEAR: begin
                        cmd.home     = 1'b1;
                        cmd.ptr_load = 1'b1;
                        cmd.ptr_sel  = PTR_ZERO;
                    end
                    OP_READ: cmd.rd_cell = 1'b1;
                    default: ;
                endcase
            end
            ST_COPY:  cmd.copy_step = 1'b1;
            ST_COPY_TAIL: begin
                // last copied word is written this cycle
                cmd.ptr_load = 1'b1;
                cmd.ptr_sel  = PTR_LAST_ROW;
            end
            ST_FILL:  cmd.fill_step  = 1'b1;
            ST_READ:  cmd.latch_data = 1'b1;
            ST_RESP:  cmd.load_out   = status.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/tcw_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Datapath: item and config registers, cursor update, cell memory with its
// sweep pointer and copy pipeline, and the result output register.
// ----------------------------------------------------------------------------
module tcw_datapath (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire tcw_pkg::tcw_cmd_t                  cmd,
    output tcw_pkg::tcw_status_t                    status,
    input  wire logic [tcw_pkg::S_DATA_W-1:0]       s_tdata,
    input  wire logic [tcw_pkg::OP_W-1:0]           s_tuser,
    input  wire logic                               cfg_valid,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [tcw_pkg::M_DATA_W-1:0]            m_tdata
);
    import tcw_pkg::*;

    // Captured item
    op_t                op_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [COLOR_W-1:0] fore_reg;
    logic [CADDR_W-1:0] caddr_reg;

    // Config
    logic [COLOR_W-1:0] bg_reg;
    logic [COLOR_W-1:0] blank_fg_reg;

    // Cursor
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             need_roll;
    logic             printable;

    // Result registers
    logic [CELL_W-1:0] data_reg;
    logic              rolled_reg;
    logic              m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // Cell memory and sweep
    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] ptr_reg;
    logic              pend_valid_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              addr_in_range;
    logic [CELL_W-1:0] blank_word;
    logic [ADDR_W-1:0] cursor_idx;

    assign blank_word    = {bg_reg, blank_fg_reg, CH_SPACE};
    assign cursor_idx    = cell_index(row_reg, col_reg);
    assign addr_in_range = 32'(caddr_reg) < CELL_COUNT;
    assign printable     = !char_reg[CHAR_W-1] && (char_reg >= CH_SPACE);

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= op_t'(s_tuser);
            char_reg  <= s_tdata[7:0];
            fore_reg  <= s_tdata[11:8];
            caddr_reg <= s_tdata[22:12];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_reg       <= '0;
            blank_fg_reg <= 4'hF;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_BACKGROUND: bg_reg       <= cfg_data;
                REG_BLANK_FG:   blank_fg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Cursor move for a put
    always_comb begin
        logic [COL_W-1:0] col_t;
        logic [ROW_W-1:0] row_t;
        col_t = col_reg;
        row_t = row_reg;
        if (char_reg == CH_BACKSPACE) begin
            if (col_reg != '0) col_t = col_reg - COL_W'(1);
        end else if (char_reg == CH_TAB) begin
            col_t = COL_W'((col_reg / COL_W'(TAB_WIDTH) + COL_W'(1)) * COL_W'(TAB_WIDTH));
        end else if (char_reg == CH_RETURN) begin
            col_t = '0;
        end else if (char_reg == CH_NEWLINE) begin
            col_t = '0;
            row_t = row_reg + ROW_W'(1);
        end else if (printable) begin
            col_t = col_reg + COL_W'(1);
        end
        // wrap past last column
        if (32'(col_t) >= COLUMNS) begin
            col_t = '0;
            row_t = row_t + ROW_W'(1);
        end
        need_roll = 32'(row_t) >= ROWS;
        col_next  = col_t;
        row_next  = need_roll ? ROW_W'(ROWS - 1) : row_t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.home) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.put) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Sweep pointer and copy pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= cmd.copy_step;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= ptr_reg - ADDR_W'(COLUMNS);
        if (cmd.ptr_load) begin
            case (cmd.ptr_sel)
                PTR_ZERO:       ptr_reg <= '0;
                PTR_SECOND_ROW: ptr_reg <= ADDR_W'(COLUMNS);
                PTR_LAST_ROW:   ptr_reg <= ADDR_W'((ROWS - 1) * COLUMNS);
                default:        ptr_reg <= '0;
            endcase
        end else if (cmd.copy_step || cmd.fill_step) begin
            ptr_reg <= ptr_reg + ADDR_W'(1);
        end
    end

    // Memory port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = blank_word;
        if (pend_valid_reg) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = rd_data_reg;
        end else if (cmd.fill_step) begin
            wr_en = 1'b1;
        end else if (cmd.put && printable) begin
            wr_en   = 1'b1;
            wr_addr = cursor_idx;
            wr_data = {bg_reg, fore_reg, char_reg};
        end
        rd_en   = cmd.copy_step || (cmd.rd_cell && addr_in_range);
        rd_addr = cmd.copy_step ? ptr_reg : ADDR_W'(caddr_reg);
    end

    // Cell memory
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    // Per-item result fields
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            data_reg   <= '0;
            rolled_reg <= 1'b0;
        end else begin
            if (cmd.put) rolled_reg <= need_roll;
            if (cmd.latch_data) data_reg <= addr_in_range ? rd_data_reg : '0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= {4'b0, rolled_reg, data_reg, LOC_W'(cursor_idx)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign status.op        = op_reg;
    assign status.need_roll = need_roll;
    assign status.ptr_last  = 32'(ptr_reg) == CELL_COUNT - 1;
    assign status.out_free  = !m_valid_reg || m_tready;

    // Checks
    a_cursor_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(row_reg) < ROWS) && (32'(col_reg) < COLUMNS))
        else $error("cursor outside the grid");

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pend_valid_reg && (cmd.fill_step || cmd.put)))
        else $error("copy write collides with another write");

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.copy_step || cmd.fill_step) |-> (32'(ptr_reg) < CELL_COUNT))
        else $error("sweep pointer past the end");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a pending word");

endmodule
`default_nettype wire

// ----- rtl/text_console_writer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console with an 80x25 cell memory and cursor; put, clear and read.
// ----------------------------------------------------------------------------
// One item is taken at a time; each gives one result word. A put that does
// not roll the screen and any other item that touches no sweep go from the
// accept through execute to the result hand-off; a read adds a cell read
// and a data latch before the hand-off. A put that runs past the last row
// and a clear both sweep the single-write-port cell memory one cell a
// cycle: a clear blanks all CELL_COUNT cells, a rolling put copies 1920
// words up one row, drains the last copy write and then blanks the 80
// cells of the last row. The result word appears in the same cycle as the
// earliest next accept. The next item is accepted once the result has
// moved into the output register, so a stalled receiver holds off the
// input behind one waiting word. Configuration writes are always accepted.
module text_console_writer_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input words
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [tcw_pkg::S_DATA_W-1:0]       s_tdata,  // char_code, fore_color, cell_address
    input  wire logic [tcw_pkg::OP_W-1:0]           s_tuser,  // op
    // result words
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [tcw_pkg::M_DATA_W-1:0]            m_tdata,  // cursor_location, cell_data, roll flag
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t status;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire
